// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with arst_n as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TEA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TEA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/tea_pkg.sv
// ----------------------------------------------------------------------------
// TEA package
// Constants, register codes, item and key types and the round mix function.
// ----------------------------------------------------------------------------
`default_nettype none

package tea_pkg;

	localparam int unsigned ROUND_COUNT_DEF = 32;
	localparam int unsigned WORD_W          = 32;

	localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

	// command key, loaded at reset
	localparam logic [WORD_W-1:0] KEY0_RST = 32'hB0F6_FE55;
	localparam logic [WORD_W-1:0] KEY1_RST = 32'h410B_BF62;
	localparam logic [WORD_W-1:0] KEY2_RST = 32'hB47C_B3C9;
	localparam logic [WORD_W-1:0] KEY3_RST = 32'h7B29_3E97;

	localparam logic KIND_ENC = 1'b0;
	localparam logic KIND_DEC = 1'b1;

	typedef enum logic [1:0] {
		REG_KEY0 = 2'd0,
		REG_KEY1 = 2'd1,
		REG_KEY2 = 2'd2,
		REG_KEY3 = 2'd3
	} tea_reg_t;

	typedef struct packed {
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w1;
		logic [WORD_W-1:0] w2;
		logic [WORD_W-1:0] w3;
	} tea_key_t;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] first;
		logic [WORD_W-1:0] second;
	} tea_item_t;

	function automatic logic [WORD_W-1:0] mix_term(
		input logic [WORD_W-1:0] v,
		input logic [WORD_W-1:0] sum,
		input logic [WORD_W-1:0] ka,
		input logic [WORD_W-1:0] kb
	);
		return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
	endfunction

endpackage

`default_nettype wire

// File: src/tea_key_regs.sv
// ----------------------------------------------------------------------------
// TEA key registers
// Four 32-bit key words, written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_key_regs import tea_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [WORD_W-1:0] cfg_data,
	output tea_key_t               key
);

	tea_key_t key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q.w0 <= KEY0_RST;
			key_q.w1 <= KEY1_RST;
			key_q.w2 <= KEY2_RST;
			key_q.w3 <= KEY3_RST;
		end else if (cfg_write) begin
			unique case (tea_reg_t'(cfg_index))
				REG_KEY0: key_q.w0 <= cfg_data;
				REG_KEY1: key_q.w1 <= cfg_data;
				REG_KEY2: key_q.w2 <= cfg_data;
				REG_KEY3: key_q.w3 <= cfg_data;
			endcase
		end
	end

	assign key = key_q;

endmodule

`default_nettype wire

// File: src/tea_round_stage.sv
// ----------------------------------------------------------------------------
// TEA half-round stage
// One registered half-round, either direction, chosen per request.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_round_stage import tea_pkg::*; #(
	parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF,
	parameter int unsigned STAGE       = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  wire logic      valid_in,
	input  wire tea_item_t item_in,
	input  wire tea_key_t  key,
	output logic           valid_out,
	output tea_item_t      item_out
);

	localparam int unsigned RND      = STAGE / 2;
	localparam logic        ODD      = 1'(STAGE % 2);
	localparam logic [63:0] ENC_PROD = 64'(TEA_DELTA) * 64'(RND + 1);
	localparam logic [63:0] DEC_PROD = 64'(TEA_DELTA) * 64'(ROUND_COUNT - RND);
	localparam logic [WORD_W-1:0] ENC_SUM = ENC_PROD[WORD_W-1:0];
	localparam logic [WORD_W-1:0] DEC_SUM = DEC_PROD[WORD_W-1:0];

	logic              upd_first;
	logic [WORD_W-1:0] src;
	logic [WORD_W-1:0] dst;
	logic [WORD_W-1:0] ka;
	logic [WORD_W-1:0] kb;
	logic [WORD_W-1:0] sum;
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] res;
	tea_item_t         item_nx;

	logic      valid_s1;
	tea_item_t item_s1;

	// encrypt updates the first word on even stages, decrypt on odd ones
	always_comb begin
		upd_first = (item_in.kind == ODD);
		src       = upd_first ? item_in.second : item_in.first;
		dst       = upd_first ? item_in.first  : item_in.second;
		ka        = upd_first ? key.w0 : key.w2;
		kb        = upd_first ? key.w1 : key.w3;
		sum       = (item_in.kind == KIND_DEC) ? DEC_SUM : ENC_SUM;
		mix       = mix_term(src, sum, ka, kb);
		res       = (item_in.kind == KIND_DEC) ? dst - mix : dst + mix;
		item_nx.kind   = item_in.kind;
		item_nx.first  = upd_first ? res : item_in.first;
		item_nx.second = upd_first ? item_in.second : res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_nx;
		end
	end

	assign valid_out = valid_s1;
	assign item_out  = item_s1;

endmodule

`default_nettype wire

// File: src/tea_block_cipher.sv
// ----------------------------------------------------------------------------
// TEA block cipher
// Pipelined Tiny Encryption Algorithm, one half-round per stage.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  input    in_valid / in_stall   kind, block_first, block_second
//  output   out_valid / out_stall out_first, out_second
//  config   cfg_write             cfg_index, cfg_data
//
//  Accepts one request per cycle while no result is stalled; each request
//  passes through the half-round stages in order, the last stage being the output.
//  Reset clears all stage valid bits and loads the command key.
//  A stalled result freezes the whole pipeline; in_stall follows it directly.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_block_cipher import tea_pkg::*; #(
	parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [WORD_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              kind,
	input  wire logic [WORD_W-1:0] block_first,
	input  wire logic [WORD_W-1:0] block_second,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [WORD_W-1:0]      out_first,
	output logic [WORD_W-1:0]      out_second
);

	localparam int unsigned STAGES = 2 * ROUND_COUNT;

	tea_key_t  key;
	logic      adv;
	logic      stage_valid [STAGES+1];
	tea_item_t stage_item  [STAGES+1];

	tea_key_regs u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key)
	);

	// hold everything while the result waits
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	assign stage_valid[0]       = in_valid;
	assign stage_item[0].kind   = kind;
	assign stage_item[0].first  = block_first;
	assign stage_item[0].second = block_second;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		tea_round_stage #(
			.ROUND_COUNT (ROUND_COUNT),
			.STAGE       (k)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.valid_in  (stage_valid[k]),
			.item_in   (stage_item[k]),
			.key       (key),
			.valid_out (stage_valid[k+1]),
			.item_out  (stage_item[k+1])
		);
	end

	assign out_valid  = stage_valid[STAGES];
	assign out_first  = stage_item[STAGES].first;
	assign out_second = stage_item[STAGES].second;

endmodule

`default_nettype wire

// File: src/tea_checker.sv
// ----------------------------------------------------------------------------
// TEA port checker
// Port-level checks on handshake, back-pressure and pipeline latency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
`default_nettype none

module tea_port_checker #(
	parameter int unsigned LATENCY = 64
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] out_first,
	input wire logic [31:0] out_second
);

	localparam int unsigned CNT_W = $clog2(LATENCY + 1);

	// consecutive cycles without output stall, saturating
	logic [CNT_W-1:0] free_q;
	logic             clear_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
		end else if (out_stall) begin
			free_q <= '0;
		end else if (free_q != CNT_W'(LATENCY)) begin
			free_q <= free_q + 1'b1;
		end
	end

	assign clear_run = (free_q >= CNT_W'(LATENCY - 1));

	`TEA_ASSERT_NEXT(a_out_valid_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`TEA_ASSERT_NEXT(a_out_data_hold, out_valid && out_stall, $stable(out_first) && $stable(out_second), "stalled result changed")
	`TEA_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled without a held result")
	`TEA_ASSERT_NOW(a_latency, clear_run && $past(in_valid && !in_stall, LATENCY), out_valid, "request not delivered after pipeline latency")

endmodule

bind tea_block_cipher tea_port_checker #(
	.LATENCY (2 * ROUND_COUNT)
) u_tea_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_first  (out_first),
	.out_second (out_second)
);

`default_nettype wire
